// ===== design/dph_pkg.sv =====
// Shared constants, types and temperature scaling constants for the packet histogrammer.
package dph_pkg;

	localparam int WORD_W = 16;
	localparam int BIN_W = 16;
	localparam int ENERGY_BITS = 16;
	localparam int COARSE_SHIFT = 4;
	localparam int COUNT_BITS = 32;

	localparam int FINE_AW = 16;
	localparam int FINE_DEPTH = 1 << FINE_AW;
	localparam int COARSE_AW = ENERGY_BITS - COARSE_SHIFT;
	localparam int COARSE_DEPTH = 1 << COARSE_AW;

	localparam int POS_W = 17;
	localparam int CNT_W = 17;
	localparam int TEMP_W = 17;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
	localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
	localparam logic [POS_W-1:0] POS_COUNT_LO = POS_W'(2);
	localparam logic [POS_W-1:0] POS_COUNT_HI = POS_W'(3);
	localparam logic [POS_W-1:0] POS_TEMP = POS_W'(5);
	localparam logic [POS_W-1:0] POS_ENERGY = POS_W'(8);

	localparam logic [WORD_W-1:0] HEADER_RESET = 16'h5A5A;

	localparam logic ACT_PACKET = 1'b0;
	localparam logic ACT_READ = 1'b1;
	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_BIN = 1'b1;

	localparam int TDATA_IN_W = 32;
	localparam int TUSER_IN_W = 3;
	localparam int TDATA_OUT_W = 72;

	localparam int OUT_DEPTH = 8;
	localparam int OUT_AW = 3;
	localparam logic [OUT_AW:0] OUT_LIMIT = (OUT_AW + 1)'(OUT_DEPTH);

	// temperature: q = floor(u / DIV), u = U0 - SLOPE * w (rounding folded into U0)
	localparam int TEMP_SHIFT = 20;
	localparam int TEMP_U_W = 42;
	localparam int TEMP_M_W = 20;
	localparam int TEMP_C_W = 36;
	localparam longint TEMP_U0_L = 64'sd867377810295;
	localparam longint TEMP_DIV_L = 64'sd17956590;
	localparam longint TEMP_SLOPE_L = 64'sd16000000;
	localparam logic [TEMP_C_W-1:0] TEMP_C =
		TEMP_C_W'((TEMP_U0_L <<< TEMP_SHIFT) / TEMP_DIV_L);
	localparam logic [TEMP_M_W-1:0] TEMP_M =
		TEMP_M_W'(((TEMP_SLOPE_L <<< TEMP_SHIFT) + TEMP_DIV_L / 2) / TEMP_DIV_L);
	localparam logic signed [TEMP_U_W-1:0] TEMP_U0 = TEMP_U_W'(TEMP_U0_L);
	localparam logic signed [TEMP_U_W-1:0] TEMP_DIV = TEMP_U_W'(TEMP_DIV_L);
	localparam logic signed [TEMP_U_W-1:0] TEMP_SLOPE = TEMP_U_W'(TEMP_SLOPE_L);
	localparam logic signed [TEMP_W-1:0] TEMP_ONE = TEMP_W'(1);

	typedef struct packed {
		logic valid;
		logic bump;
		logic [FINE_AW-1:0] fine_addr;
		logic [COARSE_AW-1:0] coarse_addr;
	} hist_req_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] fine_count;
		logic [COUNT_BITS-1:0] coarse_count;
	} hist_rsp_t;

endpackage

// ===== design/dph_temp.sv =====
// Pipelined word-to-temperature conversion: estimate by reciprocal, then one-step correction.
module dph_temp (
	input  logic clk,
	input  logic [dph_pkg::WORD_W-1:0] word_s1,
	output logic signed [dph_pkg::TEMP_W-1:0] temp_s4
);
	import dph_pkg::*;

	logic [TEMP_C_W-1:0] prod_s2;
	logic [WORD_W-1:0] word_s2;
	logic signed [TEMP_C_W+1:0] diff;
	logic signed [TEMP_W-1:0] est_s3, est_s4;
	logic signed [TEMP_U_W-1:0] u_s3, u_s4, chk_s4, rem;

	always_comb begin
		diff = $signed({2'b00, TEMP_C}) - $signed({2'b00, prod_s2});
	end

	always_ff @(posedge clk) begin
		prod_s2 <= TEMP_M * word_s1;
		word_s2 <= word_s1;
		est_s3 <= TEMP_W'(diff >>> TEMP_SHIFT);
		u_s3 <= TEMP_U0 - $signed({{(TEMP_U_W - WORD_W){1'b0}}, word_s2}) * TEMP_SLOPE;
		chk_s4 <= $signed(TEMP_U_W'(est_s3)) * TEMP_DIV;
		est_s4 <= est_s3;
		u_s4 <= u_s3;
	end

	// estimate is off by at most one either way
	always_comb begin
		rem = u_s4 - chk_s4;
		if (rem < 0) begin
			temp_s4 = est_s4 - TEMP_ONE;
		end else if (rem >= TEMP_DIV) begin
			temp_s4 = est_s4 + TEMP_ONE;
		end else begin
			temp_s4 = est_s4;
		end
	end

endmodule

// ===== design/dph_hist.sv =====
// Fine and coarse histogram memories with clear pass and forwarded read-modify-write.
module dph_hist (
	input  logic clk,
	input  logic arst_n,
	input  dph_pkg::hist_req_t req,
	output dph_pkg::hist_rsp_t rsp,
	output logic clearing
);
	import dph_pkg::*;

	logic [COUNT_BITS-1:0] fine_mem [FINE_DEPTH];
	logic [COUNT_BITS-1:0] coarse_mem [COARSE_DEPTH];

	logic [FINE_AW:0] clr_q;
	logic v_s1, bump_s1;
	logic [FINE_AW-1:0] fa_s1;
	logic [COARSE_AW-1:0] ca_s1;
	logic [COUNT_BITS-1:0] fine_rd_s1, coarse_rd_s1;
	logic wv_s2;
	logic [FINE_AW-1:0] wfa_s2;
	logic [COARSE_AW-1:0] wca_s2;
	logic [COUNT_BITS-1:0] wfd_s2, wcd_s2;
	logic [COUNT_BITS-1:0] fine_cur, coarse_cur, fine_new, coarse_new;

	assign clearing = !clr_q[FINE_AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			v_s1 <= 1'b0;
			bump_s1 <= 1'b0;
			wv_s2 <= 1'b0;
		end else begin
			if (clearing)
				clr_q <= clr_q + 1'b1;
			v_s1 <= req.valid;
			bump_s1 <= req.valid && req.bump;
			wv_s2 <= v_s1 && bump_s1;
		end
	end

	always_ff @(posedge clk) begin
		fa_s1 <= req.fine_addr;
		ca_s1 <= req.coarse_addr;
		wfa_s2 <= fa_s1;
		wca_s2 <= ca_s1;
		wfd_s2 <= fine_new;
		wcd_s2 <= coarse_new;
	end

	// previous word's write lands on the same edge as this word's read
	always_comb begin
		fine_cur = (wv_s2 && wfa_s2 == fa_s1) ? wfd_s2 : fine_rd_s1;
		coarse_cur = (wv_s2 && wca_s2 == ca_s1) ? wcd_s2 : coarse_rd_s1;
		fine_new = (fine_cur == {COUNT_BITS{1'b1}}) ? fine_cur : fine_cur + 1'b1;
		coarse_new = (coarse_cur == {COUNT_BITS{1'b1}}) ? coarse_cur : coarse_cur + 1'b1;
		rsp.fine_count = fine_cur;
		rsp.coarse_count = coarse_cur;
	end

	always_ff @(posedge clk) begin
		fine_rd_s1 <= fine_mem[req.fine_addr];
		coarse_rd_s1 <= coarse_mem[req.coarse_addr];
		if (clearing) begin
			fine_mem[clr_q[FINE_AW-1:0]] <= '0;
			coarse_mem[clr_q[COARSE_AW-1:0]] <= '0;
		end else if (v_s1 && bump_s1) begin
			fine_mem[fa_s1] <= fine_new;
			coarse_mem[ca_s1] <= coarse_new;
		end
	end

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req.valid)
		else $error("request issued during clear pass");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q[FINE_AW] |=> clr_q[FINE_AW])
		else $error("clear pass restarted");

	a_bump_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && bump_s1) |=> (wfd_s2 != '0 && wcd_s2 != '0))
		else $error("bumped bin wrote zero");

	a_coarse_follows_fine: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && bump_s1 && wv_s2 && wfa_s2 == fa_s1) |-> (wca_s2 == ca_s1))
		else $error("coarse bin not derived from same energy");

endmodule

// ===== design/detector_packet_histogrammer_unit.sv =====
// Top level of the detector packet histogrammer: packet parsing, pipeline and output queue.
//
// Input stream (s_axis): one word per handshake. tuser selects a packet word or a bin
// read; tlast marks the last word of a packet. Packet words update header check, event
// count, temperature and (for energy words) one fine and one coarse bin. A bin read
// returns the saturating count of one bin.
// Output stream (m_axis): one word for each bin read and one summary for each last
// packet word, in input order. tuser gives the kind.
// Configuration: cfg_we writes the expected header word; write only while idle.
// Throughput: one input word per cycle while s_axis_tready is high. Bin read-modify-write
// runs on a registered-read memory pair with forwarding from the previous write, so equal
// energies back to back do not stall.
// Result path: an accepted word runs through the four-stage temperature pipeline, and its
// result is then registered into the output queue that drives m_axis.
// Reset: control state clears at once; then a clear pass zeroes both histograms, one
// entry per cycle, over all 65536 fine entries with s_axis_tready low.
// Stall: an 8-entry output queue absorbs results; s_axis_tready drops when eight
// results are pending, so nothing is lost while m_axis_tready is low.
module detector_packet_histogrammer_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [dph_pkg::TDATA_IN_W-1:0] s_axis_tdata,   // word[15:0], bin_index[31:16]
	input  logic [dph_pkg::TUSER_IN_W-1:0] s_axis_tuser,   // action, first_word, read_coarse
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [dph_pkg::TDATA_OUT_W-1:0] m_axis_tdata,  // header_error, event_count,
	                                                       // temperature_q8, bin_count, 0
	output logic m_axis_tuser,                             // kind
	input  logic cfg_we,
	input  logic [dph_pkg::WORD_W-1:0] cfg_wdata
);
	import dph_pkg::*;

	typedef struct packed {
		logic action;
		logic last;
		logic t_load;
		logic t_clear;
		logic bad;
		logic [CNT_W-1:0] cnt;
		logic coarse_sel;
	} pipe_t;

	typedef struct packed {
		logic kind;
		logic [COUNT_BITS-1:0] bin_count;
		logic signed [TEMP_W-1:0] temperature_q8;
		logic [CNT_W-1:0] event_count;
		logic header_error;
	} out_t;

	localparam int RES_W = $bits(out_t) - 1;

	logic [WORD_W-1:0] in_word, expected_q;
	logic [BIN_W-1:0] in_bin;
	logic in_action, in_first, in_coarse, in_last;
	logic acc, pkt, produces, m_acc, emit, clearing;
	logic [POS_W-1:0] pos, wp_q, wp_nx;
	logic bad_q, bad_nx;
	logic [CNT_W-1:0] cnt_q, cnt_nx;
	logic bump;
	hist_req_t req;
	hist_rsp_t rsp;

	logic v_s1, v_s2, v_s3, v_s4;
	pipe_t p_s1, p_s2, p_s3, p_s4;
	logic [WORD_W-1:0] word_s1;
	logic [COUNT_BITS-1:0] bin_s2, bin_s3, bin_s4;
	logic signed [TEMP_W-1:0] temp_s4, temp_q, temp_now;

	out_t res;
	out_t out_mem [OUT_DEPTH];
	logic [OUT_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUT_AW:0] fifo_cnt_q, pend_q;

	assign in_word = s_axis_tdata[WORD_W-1:0];
	assign in_bin = s_axis_tdata[WORD_W+BIN_W-1:WORD_W];
	assign in_action = s_axis_tuser[0];
	assign in_first = s_axis_tuser[1];
	assign in_coarse = s_axis_tuser[2];
	assign in_last = s_axis_tlast;

	assign s_axis_tready = !clearing && (pend_q != OUT_LIMIT);
	assign acc = s_axis_tvalid && s_axis_tready;
	assign pkt = acc && (in_action == ACT_PACKET);
	assign produces = acc && ((in_action == ACT_READ) || in_last);
	assign m_acc = m_axis_tvalid && m_axis_tready;

	always_comb begin
		pos = in_first ? POS_HEADER : wp_q;
		bad_nx = bad_q;
		cnt_nx = cnt_q;
		if (pos == POS_HEADER) begin
			bad_nx = (in_word != expected_q);
			cnt_nx = '0;
		end else if (pos == POS_COUNT_LO) begin
			cnt_nx = CNT_W'(in_word);
		end else if (pos == POS_COUNT_HI) begin
			cnt_nx = cnt_q + CNT_W'(in_word);
		end
		bump = pkt && (pos >= POS_ENERGY) && ((pos - POS_ENERGY) < POS_W'(cnt_q)) && !bad_q;
		if (in_last)
			wp_nx = '0;
		else
			wp_nx = (pos == POS_MAX) ? POS_MAX : pos + 1'b1;
	end

	always_comb begin
		req.valid = acc;
		req.bump = bump;
		if (in_action == ACT_READ) begin
			req.fine_addr = FINE_AW'(in_bin);
			req.coarse_addr = in_bin[COARSE_AW-1:0];
		end else begin
			req.fine_addr = FINE_AW'(in_word[ENERGY_BITS-1:0]);
			req.coarse_addr = in_word[ENERGY_BITS-1:COARSE_SHIFT];
		end
	end

	dph_hist u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.clearing (clearing)
	);

	dph_temp u_temp (
		.clk     (clk),
		.word_s1 (word_s1),
		.temp_s4 (temp_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= HEADER_RESET;
			wp_q <= '0;
			bad_q <= 1'b0;
			cnt_q <= '0;
			temp_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (cfg_we)
				expected_q <= cfg_wdata;
			if (pkt) begin
				wp_q <= wp_nx;
				bad_q <= bad_nx;
				cnt_q <= cnt_nx;
			end
			if (v_s4)
				temp_q <= temp_now;
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		p_s1.action <= in_action;
		p_s1.last <= in_last;
		p_s1.t_load <= pkt && (pos == POS_TEMP);
		p_s1.t_clear <= pkt && (pos == POS_HEADER);
		p_s1.bad <= bad_nx;
		p_s1.cnt <= cnt_nx;
		p_s1.coarse_sel <= in_coarse;
		word_s1 <= in_word;
		p_s2 <= p_s1;
		p_s3 <= p_s2;
		p_s4 <= p_s3;
		bin_s2 <= p_s1.coarse_sel ? rsp.coarse_count : rsp.fine_count;
		bin_s3 <= bin_s2;
		bin_s4 <= bin_s3;
	end

	always_comb begin
		if (p_s4.t_load)
			temp_now = temp_s4;
		else if (p_s4.t_clear)
			temp_now = '0;
		else
			temp_now = temp_q;
		emit = v_s4 && ((p_s4.action == ACT_READ) || p_s4.last);
		res.kind = (p_s4.action == ACT_READ) ? KIND_BIN : KIND_SUMMARY;
		res.header_error = 1'b0;
		res.event_count = '0;
		res.temperature_q8 = '0;
		res.bin_count = '0;
		if (p_s4.action == ACT_READ) begin
			res.bin_count = bin_s4;
		end else if (p_s4.bad) begin
			res.header_error = 1'b1;
		end else begin
			res.event_count = p_s4.cnt;
			res.temperature_q8 = temp_now;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_mem[wr_ptr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fifo_cnt_q <= '0;
			pend_q <= '0;
		end else begin
			if (emit)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (m_acc)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({emit, m_acc})
				2'b10: fifo_cnt_q <= fifo_cnt_q + 1'b1;
				2'b01: fifo_cnt_q <= fifo_cnt_q - 1'b1;
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
			case ({produces, m_acc})
				2'b10: pend_q <= pend_q + 1'b1;
				2'b01: pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	assign m_axis_tvalid = (fifo_cnt_q != '0);
	assign m_axis_tuser = out_mem[rd_ptr_q].kind;
	assign m_axis_tdata = TDATA_OUT_W'(out_mem[rd_ptr_q][RES_W-1:0]);

	a_queue_within_pending: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= pend_q)
		else $error("queue holds more words than were accepted");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (fifo_cnt_q != OUT_LIMIT) || m_acc)
		else $error("output queue overflow");

endmodule

// ===== bench/histogram_checker.sv =====
// Checker for the packet histogrammer: tracks the stream words, predicts results, compares.
module histogram_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [dph_pkg::TDATA_IN_W-1:0] s_tdata,
	input  logic [dph_pkg::TUSER_IN_W-1:0] s_tuser,
	input  logic s_tlast,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [dph_pkg::TDATA_OUT_W-1:0] m_tdata,
	input  logic m_tuser,
	input  logic cfg_we,
	input  logic [dph_pkg::WORD_W-1:0] cfg_wdata,
	output int mismatches,
	output int outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import dph_pkg::*;

	typedef struct packed {
		logic kind;
		logic header_error;
		logic [CNT_W-1:0] event_count;
		logic [TEMP_W-1:0] temperature_q8;
		logic [COUNT_BITS-1:0] bin_count;
	} dph_result_t;

	// 256*T = 6400 * (1034*65535 - 1250*w) / (137*65535)
	localparam longint TEMP_SCALE = 6400;
	localparam longint TEMP_OFFSET = 67763190;
	localparam longint TEMP_GAIN = 1250;
	localparam longint TEMP_DENOM = 8978295;

	bit [COUNT_BITS-1:0] fine_bins [FINE_DEPTH];
	bit [COUNT_BITS-1:0] coarse_bins [COARSE_DEPTH];
	bit [POS_W-1:0] next_pos;
	bit [CNT_W-1:0] pkt_events;
	bit hdr_mismatch;
	bit [TEMP_W-1:0] pkt_temp;
	bit [WORD_W-1:0] header_reg = HEADER_RESET;
	dph_result_t expected_results [$];
	int err_total;

	function automatic logic [TEMP_W-1:0] celsius_q8(input logic [WORD_W-1:0] w);
		longint num;
		longint q;
		num = TEMP_SCALE * (TEMP_OFFSET - TEMP_GAIN * longint'(w));
		if (num >= 0)
			q = (2 * num + TEMP_DENOM) / (2 * TEMP_DENOM);
		else
			q = -((-2 * num + TEMP_DENOM) / (2 * TEMP_DENOM));
		return TEMP_W'(q);
	endfunction

	task automatic track_word(input logic action, input logic [WORD_W-1:0] w,
			input logic first, input logic last, input logic coarse,
			input logic [BIN_W-1:0] idx);
		dph_result_t r;
		logic [POS_W-1:0] pos;
		logic [ENERGY_BITS-1:0] energy;
		logic [COARSE_AW-1:0] coarse_idx;
		r = '0;
		if (action == ACT_READ) begin
			r.kind = KIND_BIN;
			coarse_idx = idx[COARSE_AW-1:0];
			r.bin_count = coarse ? coarse_bins[coarse_idx] : fine_bins[idx[FINE_AW-1:0]];
			expected_results.push_back(r);
			return;
		end
		pos = first ? POS_HEADER : next_pos;
		if (pos == POS_HEADER) begin
			hdr_mismatch = (w != header_reg);
			pkt_events = '0;
			pkt_temp = '0;
		end else if (pos == POS_COUNT_LO) begin
			pkt_events = CNT_W'(w);
		end else if (pos == POS_COUNT_HI) begin
			pkt_events = pkt_events + CNT_W'(w);
		end else if (pos == POS_TEMP) begin
			pkt_temp = celsius_q8(w);
		end else if (pos >= POS_ENERGY && (pos - POS_ENERGY) < pkt_events && !hdr_mismatch) begin
			energy = w[ENERGY_BITS-1:0];
			coarse_idx = COARSE_AW'(energy >> COARSE_SHIFT);
			if (fine_bins[energy] != '1)
				fine_bins[energy] = fine_bins[energy] + 1'b1;
			if (coarse_bins[coarse_idx] != '1)
				coarse_bins[coarse_idx] = coarse_bins[coarse_idx] + 1'b1;
		end
		next_pos = (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
		if (last) begin
			next_pos = '0;
			r.kind = KIND_SUMMARY;
			r.header_error = hdr_mismatch;
			r.event_count = hdr_mismatch ? '0 : pkt_events;
			r.temperature_q8 = hdr_mismatch ? '0 : pkt_temp;
			expected_results.push_back(r);
		end
	endtask

	function automatic int field_differs(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want === got)
			return 0;
		$error("%s: expected %0h, got %0h", name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dph_result_t got;
		dph_result_t want;
		if (!arst_n) begin
			foreach (fine_bins[i]) fine_bins[i] = '0;
			foreach (coarse_bins[i]) coarse_bins[i] = '0;
			next_pos = '0;
			pkt_events = '0;
			hdr_mismatch = 1'b0;
			pkt_temp = '0;
			header_reg = HEADER_RESET;
			expected_results.delete();
			outstanding <= 0;
			mismatches <= err_total;
		end else begin
			if (cfg_we)
				header_reg = cfg_wdata;
			if (s_tvalid && s_tready)
				track_word(s_tuser[0], s_tdata[15:0], s_tuser[1], s_tlast, s_tuser[2],
					s_tdata[31:16]);
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.header_error = m_tdata[0];
				got.event_count = m_tdata[17:1];
				got.temperature_q8 = m_tdata[34:18];
				got.bin_count = m_tdata[66:35];
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected: kind %0d data %0h",
						got.kind, m_tdata);
					err_total++;
				end else begin
					want = expected_results.pop_front();
					err_total += field_differs("kind", 32'(want.kind), 32'(got.kind));
					err_total += field_differs("header_error", 32'(want.header_error),
						32'(got.header_error));
					err_total += field_differs("event_count", 32'(want.event_count),
						32'(got.event_count));
					err_total += field_differs("temperature_q8", 32'(want.temperature_q8),
						32'(got.temperature_q8));
					err_total += field_differs("bin_count", want.bin_count, got.bin_count);
				end
			end
			mismatches <= err_total;
			outstanding <= expected_results.size();
		end
	end

endmodule

// ===== bench/tb_detector_packet_histogrammer_unit.sv =====
// Testbench top for the packet histogrammer: clock, reset, stimulus and verdict.
module tb_detector_packet_histogrammer_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import dph_pkg::*;

	localparam int HOLD_LEN = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS = 360;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TDATA_IN_W-1:0] s_tdata = '0;
	logic [TUSER_IN_W-1:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [WORD_W-1:0] cfg_wdata = '0;

	int mismatches;
	int outstanding;
	int send_idle_pct = 0;
	int stall_pct = 0;
	logic long_hold = 1'b0;
	int hold_count = 0;
	bit hold_done = 1'b0;
	int words_sent = 0;
	logic [WORD_W-1:0] cur_header = HEADER_RESET;
	logic [WORD_W-1:0] hot_base = 16'h1230;
	logic [WORD_W-1:0] last_energy = '0;

	detector_packet_histogrammer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata(s_tdata),
		.s_axis_tuser(s_tuser),
		.s_axis_tlast(s_tlast),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_tdata),
		.m_axis_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	histogram_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always #10 clk = ~clk;

	// receiver: one long hold-off when asked, random stalls otherwise
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (long_hold && !hold_done) begin
			m_tready <= 1'b0;
			hold_count <= hold_count + 1;
			if (hold_count == HOLD_LEN - 1)
				hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	task automatic send_word(input logic action, input logic [WORD_W-1:0] w,
			input logic first, input logic last, input logic coarse,
			input logic [BIN_W-1:0] idx);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {idx, w};
		s_tuser <= {coarse, first, action};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	// block is idle once nothing is expected and the pipeline has flushed
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_header(input logic [WORD_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_header = value;
		@(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] pick_energy();
		case ($urandom_range(0, 3))
			0: ;  // repeat, back-to-back equal bins
			1: last_energy = hot_base + WORD_W'($urandom_range(0, 31));
			2: last_energy = WORD_W'($urandom);
			default: last_energy = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		endcase
		return last_energy;
	endfunction

	task automatic send_read();
		logic [BIN_W-1:0] idx;
		logic coarse;
		coarse = 1'($urandom);
		if ($urandom_range(0, 1))
			idx = BIN_W'($urandom);
		else if (coarse)
			idx = {4'($urandom), 12'((hot_base + $urandom_range(0, 31)) >> COARSE_SHIFT)};
		else
			idx = hot_base + BIN_W'($urandom_range(0, 31));
		send_word(ACT_READ, WORD_W'($urandom), 1'($urandom), 1'($urandom), coarse, idx);
	endtask

	task automatic send_packet(input bit hdr_ok, input bit mark_first, input int n_energy,
			input int stop_at, input bit big_count, input bit close_it);
		int total;
		int split;
		logic [WORD_W-1:0] w;
		split = $urandom_range(0, n_energy);
		total = 8 + n_energy + $urandom_range(0, 2);
		if (stop_at > 0 && stop_at < total)
			total = stop_at;
		for (int pos = 0; pos < total; pos++) begin
			case (pos)
				0: w = hdr_ok ? cur_header : cur_header ^ (16'd1 << $urandom_range(0, 15));
				2: w = big_count ? 16'hFFFF : WORD_W'(split);
				3: w = big_count ? WORD_W'($urandom) : WORD_W'(n_energy - split);
				default: w = (pos >= 8) ? pick_energy() : WORD_W'($urandom);
			endcase
			if ($urandom_range(0, 9) == 0)
				send_read();
			send_word(ACT_PACKET, w, mark_first && pos == 0, close_it && pos == total - 1,
				1'($urandom), BIN_W'($urandom));
		end
	endtask

	task automatic random_phase(input int target);
		int r;
		while (words_sent < target) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 19) == 0)
				drain();
			if (r < 60)
				send_packet(1, 1'($urandom), $urandom_range(0, 6), 0, 0, 1);
			else if (r < 80)
				send_read();
			else if (r < 87)
				send_packet(0, 1'($urandom), $urandom_range(0, 4), 0, 0, 1);
			else if (r < 93)
				send_packet(1, 1'($urandom), $urandom_range(0, 4), $urandom_range(1, 8), 0, 1);
			else if (r < 97) begin
				// packet broken off, then restarted by a first word
				send_packet($urandom_range(0, 1), 1, $urandom_range(0, 3),
					$urandom_range(1, 11), 0, 0);
				send_packet(1, 1, $urandom_range(0, 6), 0, 0, 1);
			end else
				send_packet(1, 1'($urandom), $urandom_range(0, 5), 0, 1, 1);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: good packet, energy extremes, equal energies back to back
		send_word(ACT_PACKET, HEADER_RESET, 1, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'h1111, 0, 0, 1, 16'hFFFF);
		send_word(ACT_PACKET, 16'h0002, 0, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'h0001, 0, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'h4444, 0, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'h0000, 0, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'h6666, 0, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'h7777, 0, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'hFFFF, 0, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'hFFFF, 0, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'h0000, 0, 1, 0, 16'h0000);
		// reads of both stores, coarse index wraps
		send_word(ACT_READ, 16'h0000, 0, 0, 0, 16'hFFFF);
		send_word(ACT_READ, 16'hFFFF, 1, 1, 1, 16'hFFFF);
		send_word(ACT_READ, 16'h0000, 0, 0, 0, 16'h0000);
		send_word(ACT_READ, 16'h0000, 0, 0, 1, 16'h0000);
		// bad header, cut short
		send_word(ACT_PACKET, 16'hA5A5, 1, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'h0001, 0, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'h0003, 0, 1, 0, 16'h0000);
		// no first flag after a last word; count carries into its top bit, coldest reading
		send_word(ACT_PACKET, HEADER_RESET, 0, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'h0001, 0, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'h0007, 0, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'hFFFF, 0, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'h0004, 0, 0, 0, 16'h0000);
		send_word(ACT_PACKET, 16'hFFFF, 0, 1, 0, 16'h0000);
		// one-word packet
		send_word(ACT_PACKET, HEADER_RESET, 1, 1, 0, 16'h0000);

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
				0: write_header(16'h0000);
				1: write_header(16'hFFFF);
				default: write_header(WORD_W'($urandom));
			endcase
			hot_base = WORD_W'($urandom);
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
					long_hold <= 1'b1;
				end
				1: begin
					send_idle_pct = 72;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 72;
				end
				default: begin
					send_idle_pct = 30;
					stall_pct = 30;
				end
			endcase
			random_phase(words_sent + PHASE_ITEMS);
		end

		drain();
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
